// ===== sv/lppr_pkg.sv =====
// Shared constants and the controller/datapath command and status types
// for the longest palindrome-permutable run block. No dependencies.
package lppr_pkg;

    // string length limit and derived position width
    localparam int MAX_LEN = 65535;
    localparam int POS_W   = $clog2(MAX_LEN + 1);

    // digit and parity mask
    localparam int NUM_DIGITS = 10;
    localparam int MASK_W     = NUM_DIGITS;
    localparam int DIGIT_W    = 4;
    localparam int DEPTH      = 2 ** MASK_W;

    // reported length, saturating
    localparam int               LEN_W   = 16;
    localparam int               BEST_W  = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam logic [LEN_W-1:0] LEN_SAT = '1;

    // string epoch tag kept with each table entry, zero marks a cleared entry
    localparam int                 EPOCH_W     = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam int                 ENT_W       = EPOCH_W + POS_W;

    // probes per digit: the mask itself and its one-bit neighbors
    localparam int PROBES = NUM_DIGITS + 1;
    localparam int CNT_W  = $clog2(PROBES + 1);

    // controller to datapath
    typedef struct packed {
        logic             accept;
        logic             clear;
        logic [CNT_W-1:0] idx;
        logic             eval;
        logic             eval_first;
        logic             write;
        logic             load_out;
    } lppr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic wrap_now;
        logic adv_now;
        logic adv;
        logic clr_last;
        logic out_busy;
    } lppr_stat_t;

endpackage

// ===== sv/longest_palindromic_permutation_run.sv =====
// Top level of the longest palindrome-permutable run block: controller and
// datapath joined by command and status structs. Depends on lppr_pkg.
//
// Each input item carries one decimal digit and a start flag; each item gives
// exactly one result item with the longest length, so far in the current
// string, of a substring whose digits can be rearranged into a palindrome, plus
// an overflow flag for digits dropped past the string limit. A digit passes
// through the accept state, the reads of the current parity mask and its ten
// neighbors from the single-port 1024-entry first-position table (reads are
// pipelined, one per cycle), and the conditional table update. Digits above
// nine and dropped digits skip the reads. After reset, and on every 63rd string
// start, a clearing pass sweeps the table while no item is accepted. A finished
// result sits in an output register; the next item is taken while it waits.
module longest_palindromic_permutation_run (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] digit
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] best_length
    output logic        m_tuser    // [0] overflow
);
    import lppr_pkg::*;

    lppr_cmd_t  cmd;
    lppr_stat_t stat;

    // sequencing
    lppr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // mask, table and result
    lppr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== sv/lppr_ctrl.sv =====
// Sequencing state machine: table clearing pass, item accept, probe
// sequence, table update and result hand-off. Depends on lppr_pkg.
module lppr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lppr_pkg::lppr_stat_t stat,
    output lppr_pkg::lppr_cmd_t  cmd
);
    import lppr_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // input side open only between items
    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    pend_next = 1'b0;
                    cnt_next  = '0;
                    if (!pend_reg)
                        state_next = ST_IDLE;
                    else if (stat.adv)
                        state_next = ST_PROBE;
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    if (stat.wrap_now)
                    begin
                        pend_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else if (stat.adv_now)
                        state_next = ST_PROBE;
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_PROBE:
            begin
                cmd.idx        = cnt_reg;
                cmd.eval       = (cnt_reg != '0);
                cmd.eval_first = (cnt_reg == CNT_W'(1));
                if (cnt_reg == CNT_W'(PROBES))
                    state_next = ST_WRITE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== sv/lppr_dp.sv =====
// Datapath: parity mask, position, best length, first-position table
// memory with epoch tags, and the output register. Depends on lppr_pkg.
module lppr_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           s_tdata,   // [3:0] digit
    input  logic                 s_tuser,   // [0] start_req
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] best_length
    output logic                 m_tuser,   // [0] overflow
    input  lppr_pkg::lppr_cmd_t  cmd,
    output lppr_pkg::lppr_stat_t stat
);
    import lppr_pkg::*;

    logic [MASK_W-1:0]  mask_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   best_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               adv_reg;
    logic               ovf_reg;
    logic               cur_valid_reg;
    logic [MASK_W-1:0]  clr_addr_reg;
    logic [ENT_W-1:0]   rd_data_reg;
    logic               rd_zero_reg;
    logic               m_valid_reg;
    logic [LEN_W-1:0]   m_data_reg;
    logic               m_user_reg;

    logic [DIGIT_W-1:0] digit;
    logic               start;
    logic [MASK_W-1:0]  mask_eff;
    logic [POS_W-1:0]   pos_eff;
    logic               digit_ok;
    logic               room;
    logic               adv_now;
    logic [MASK_W-1:0]  digit_bit;
    logic [MASK_W-1:0]  probe_addr;
    logic [MASK_W-1:0]  mem_addr;
    logic               mem_we;
    logic [ENT_W-1:0]   mem_wdata;
    logic [EPOCH_W-1:0] rd_tag;
    logic [POS_W-1:0]   rd_pos;
    logic               hit;
    logic [POS_W-1:0]   cand;
    logic [BEST_W-1:0]  best_ext;
    logic [LEN_W-1:0]   best_sat;
    logic               out_busy;

    logic [ENT_W-1:0] mem [DEPTH];

    // incoming item, with a start taking effect before the digit
    assign digit     = s_tdata[DIGIT_W-1:0];
    assign start     = s_tuser;
    assign mask_eff  = start ? '0 : mask_reg;
    assign pos_eff   = start ? '0 : pos_reg;
    assign digit_ok  = (digit < DIGIT_W'(NUM_DIGITS));
    assign room      = (pos_eff < POS_W'(MAX_LEN));
    assign adv_now   = digit_ok && room;
    assign digit_bit = MASK_W'(1) << digit;

    // probe address: the mask itself, then each one-bit neighbor
    assign probe_addr = (cmd.idx == '0) ? mask_reg
                        : (mask_reg ^ (MASK_W'(1) << (cmd.idx - CNT_W'(1))));

    // single table port shared by clearing, probing and update
    assign mem_addr  = cmd.clear ? clr_addr_reg : (cmd.write ? mask_reg : probe_addr);
    assign mem_we    = cmd.clear || (cmd.write && adv_reg && !cur_valid_reg);
    assign mem_wdata = cmd.clear ? '0 : {epoch_reg, pos_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
        rd_zero_reg <= (mem_addr == '0);
    end

    // probe result: entry zero always holds position zero
    assign rd_tag = rd_data_reg[ENT_W-1:POS_W];
    assign rd_pos = rd_data_reg[POS_W-1:0];
    assign hit    = rd_zero_reg || (rd_tag == epoch_reg);
    assign cand   = pos_reg - (rd_zero_reg ? '0 : rd_pos);

    // status to the controller
    assign out_busy      = m_valid_reg && !m_tready;
    assign stat.wrap_now = start && (epoch_reg == EPOCH_MAX);
    assign stat.adv_now  = adv_now;
    assign stat.adv      = adv_reg;
    assign stat.clr_last = (clr_addr_reg == '1);
    assign stat.out_busy = out_busy;

    // string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            pos_reg       <= '0;
            best_reg      <= POS_W'(1);
            epoch_reg     <= EPOCH_FIRST;
            adv_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            cur_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                adv_reg  <= adv_now;
                ovf_reg  <= digit_ok && !room;
                mask_reg <= adv_now ? (mask_eff ^ digit_bit) : mask_eff;
                pos_reg  <= adv_now ? (pos_eff + POS_W'(1)) : pos_eff;
                if (start)
                begin
                    best_reg  <= POS_W'(1);
                    epoch_reg <= (epoch_reg == EPOCH_MAX) ? EPOCH_FIRST
                                 : (epoch_reg + EPOCH_W'(1));
                end
            end
            if (cmd.clear)
                clr_addr_reg <= clr_addr_reg + MASK_W'(1);
            if (cmd.eval)
            begin
                if (hit && (cand > best_reg))
                    best_reg <= cand;
                if (cmd.eval_first)
                    cur_valid_reg <= hit;
            end
        end
    end

    // saturate the reported length
    assign best_ext = BEST_W'(best_reg);
    assign best_sat = (best_ext > BEST_W'(LEN_SAT)) ? LEN_SAT : best_ext[LEN_W-1:0];

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_data_reg <= best_sat;
            m_user_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    // best length only drops when a new string starts
    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.accept |=> best_reg >= $past(best_reg))
        else $error("best length decreased without a new string");

    // entry zero is fixed and never written by a table update
    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && mem_we) |-> mask_reg != '0)
        else $error("table update aimed at entry zero");

    // a pending result is never overwritten
    a_no_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_busy)
        else $error("output register loaded while a result waits");

    // position stays within the string limit
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_LEN))
        else $error("position beyond string limit");

    // the cleared tag is never the live epoch
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch collides with cleared tag");
`endif

endmodule
